// ----- rtl/egcd_pkg.sv -----
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended GCD unit: the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package egcd_pkg;

  typedef struct packed {
    logic load;       // take a new operand pair and reset the coefficients
    logic div_start;  // clear the divider and the product accumulators
    logic div_step;   // one restoring-division bit with product accumulation
    logic update;     // retire one Euclid step
    logic capture;    // copy the finished result into the output register
  } egcd_cmd_t;

  typedef struct packed {
    logic rem_zero;   // current remainder is zero: the sequence has ended
  } egcd_sts_t;

endpackage

// ----- rtl/egcd_datapath.sv -----
// ----------------------------------------------------------------------------
// egcd_datapath
// Remainder and coefficient registers, a shared bit-serial divider, and the
// output register. The divider produces quotient bits from the top down, and
// each bit also folds the current coefficients into running products, so
// q*x and q*y are ready when the remainder is.
// ----------------------------------------------------------------------------
module egcd_datapath
  import egcd_pkg::*;
#(
  parameter int DATA_BITS = 31
) (
  input  logic                        clk,
  input  egcd_cmd_t                   cmd,
  output egcd_sts_t                   sts,
  input  logic [DATA_BITS-1:0]        first_value,
  input  logic [DATA_BITS-1:0]        second_value,
  output logic [DATA_BITS-1:0]        divisor,
  output logic signed [DATA_BITS:0]   coeff_first,
  output logic signed [DATA_BITS:0]   coeff_second
);

  logic [DATA_BITS-1:0] rem_old_r, rem_cur_r;
  logic [DATA_BITS:0]   xs_old_r, xs_cur_r, ys_old_r, ys_cur_r;
  logic [DATA_BITS-1:0] part_r;    // partial remainder of the divider
  logic [DATA_BITS-1:0] dvd_r;     // dividend, shifted out from the top
  logic [DATA_BITS:0]   accx_r, accy_r;
  logic [DATA_BITS-1:0] out_div_r;
  logic [DATA_BITS:0]   out_x_r, out_y_r;

  logic [DATA_BITS:0]   trial;
  logic                 fits;
  logic [DATA_BITS:0]   trial_sub;
  logic [DATA_BITS-1:0] part_nxt;
  logic [DATA_BITS:0]   accx_nxt, accy_nxt;

  always_comb begin
    trial     = {part_r, dvd_r[DATA_BITS-1]};
    fits      = (trial >= {1'b0, rem_cur_r});
    trial_sub = trial - {1'b0, rem_cur_r};
    // The partial remainder stays below the divisor, so it fits the data width.
    part_nxt  = fits ? trial_sub[DATA_BITS-1:0] : trial[DATA_BITS-1:0];
    accx_nxt  = {accx_r[DATA_BITS-1:0], 1'b0} + (fits ? xs_cur_r : '0);
    accy_nxt  = {accy_r[DATA_BITS-1:0], 1'b0} + (fits ? ys_cur_r : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_old_r <= first_value;
      rem_cur_r <= second_value;
      xs_old_r  <= (DATA_BITS+1)'(1);
      xs_cur_r  <= '0;
      ys_old_r  <= '0;
      ys_cur_r  <= (DATA_BITS+1)'(1);
    end else if (cmd.update) begin
      rem_old_r <= rem_cur_r;
      rem_cur_r <= part_r;
      xs_old_r  <= xs_cur_r;
      xs_cur_r  <= xs_old_r - accx_r;
      ys_old_r  <= ys_cur_r;
      ys_cur_r  <= ys_old_r - accy_r;
    end

    if (cmd.div_start) begin
      part_r <= '0;
      dvd_r  <= rem_old_r;
      accx_r <= '0;
      accy_r <= '0;
    end else if (cmd.div_step) begin
      part_r <= part_nxt;
      dvd_r  <= {dvd_r[DATA_BITS-2:0], 1'b0};
      accx_r <= accx_nxt;
      accy_r <= accy_nxt;
    end

    if (cmd.capture) begin
      out_div_r <= rem_old_r;
      out_x_r   <= xs_old_r;
      out_y_r   <= ys_old_r;
    end
  end

  assign sts.rem_zero = (rem_cur_r == '0);
  assign divisor      = out_div_r;
  assign coeff_first  = $signed(out_x_r);
  assign coeff_second = $signed(out_y_r);

endmodule

// ----- rtl/egcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// egcd_ctrl
// Sequencer for the extended GCD unit. It loads an operand pair, runs one
// Euclid step after another through the shared divider until the remainder
// is zero, and hands the result to the output register.
// ----------------------------------------------------------------------------
module egcd_ctrl
  import egcd_pkg::*;
#(
  parameter int DATA_BITS = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output egcd_cmd_t cmd,
  input  egcd_sts_t sts
);

  localparam int CNT_BITS = $clog2(DATA_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_HOLD
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  // The output register can take a result if it is empty or being emptied.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.rem_zero) begin
          if (out_free) begin
            cmd.capture = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end else begin
          cmd.div_start = 1'b1;
          cnt_nxt       = CNT_BITS'(DATA_BITS - 1);
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_UPDATE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // An accepted item closes the input until its result has been handed over.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item was still in progress");

  // The bit counter is idle outside the division.
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIV) |-> (cnt_r == '0))
    else $error("divider bit counter not at rest outside division");

  // A step is only retired against a nonzero divisor.
  a_update_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> !sts.rem_zero)
    else $error("Euclid step retired with zero divisor");

  // A result appears only once the remainder sequence has ended.
  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(sts.rem_zero))
    else $error("result presented before the remainder reached zero");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> out_free)
    else $error("output register overwritten while stalled");

endmodule

// ----- rtl/extended_gcd_unit.sv -----
// ----------------------------------------------------------------------------
// extended_gcd_unit
// Extended Euclidean algorithm: gcd of two unsigned operands and the Bezout
// coefficients x, y with first*x + second*y = gcd.
//
// Input channel: in_valid / in_stall with in_first_value and in_second_value.
// An item is taken when in_valid is high and in_stall is low. in_stall is
// high from the cycle after an item is taken until that item's result has
// been written into the output register.
// Output channel: out_valid / out_stall with out_divisor, out_coeff_first and
// out_coeff_second (two's complement). The result stays in the output
// register until it is taken, and a new item may be accepted meanwhile.
// Each Euclid step runs the shared bit-serial divider over all DATA_BITS
// quotient bits, between a check and an update state; 31-bit operands need
// at most 45 steps (neighbouring Fibonacci numbers, smaller first). A zero
// second operand skips the divider. The next item can be taken in the cycle
// its predecessor's result appears. If the receiver stalls with a result
// still held, the next finished result waits in the unit and no further
// item is accepted.
// Reset (synchronous, rst_n low) returns the unit to idle with no result
// pending.
// ----------------------------------------------------------------------------
module extended_gcd_unit
  import egcd_pkg::*;
#(
  parameter int DATA_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [DATA_BITS-1:0]      in_first_value,
  input  logic [DATA_BITS-1:0]      in_second_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DATA_BITS-1:0]      out_divisor,
  output logic signed [DATA_BITS:0] out_coeff_first,
  output logic signed [DATA_BITS:0] out_coeff_second
);

  egcd_cmd_t cmd;
  egcd_sts_t sts;

  egcd_ctrl #(
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  egcd_datapath #(
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .first_value  (in_first_value),
    .second_value (in_second_value),
    .divisor      (out_divisor),
    .coeff_first  (out_coeff_first),
    .coeff_second (out_coeff_second)
  );

endmodule
